### sv/tccc_pkg.sv
// Shared constants and the arctangent table of the compass heading pipeline.
package tccc_pkg;

    localparam int FRAC          = 30;
    localparam int QW            = FRAC + 1;
    localparam int ZW            = 32;
    localparam int ANG_SHIFT     = 14;
    localparam int ANG_ROUND     = 8192;
    localparam int ANG_HALF_TURN = 188743680;
    localparam int TURN_UNITS    = 23040;
    localparam int HEADING_W     = 15;
    localparam int ATAN_W        = 26;
    localparam int ATAN_N        = 24;

    // atan(2^-i) in units of 2^-20 degree.
    localparam logic [ATAN_W-1:0] ATAN_DEG_TAB [ATAN_N] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
        26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
        26'd234682,   26'd117342,   26'd58671,    26'd29335,
        26'd14668,    26'd7334,     26'd3667,     26'd1833,
        26'd917,      26'd458,      26'd229,      26'd115,
        26'd57,       26'd29,       26'd14,       26'd7
    };

endpackage

### sv/tccc_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module tccc_sqrt_cell #(
    parameter int W = 32,
    parameter int J = 0
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] x_in,
    input  logic [W-1:0] res_in,
    output logic [W-1:0] x_out,
    output logic [W-1:0] res_out
);

    localparam logic [W:0] BIT = (W+1)'(1) << (2 * J);

    logic [W:0] trial;

    assign trial = {1'b0, res_in} + BIT;

    always_ff @(posedge aclk) begin
        if (en) begin
            if ({1'b0, x_in} >= trial) begin
                x_out   <= x_in - trial[W-1:0];
                res_out <= (res_in >> 1) + BIT[W-1:0];
            end else begin
                x_out   <= x_in;
                res_out <= res_in >> 1;
            end
        end
    end

endmodule

### sv/tccc_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
module tccc_div_cell #(
    parameter int NW    = 16,
    parameter bit FIRST = 1'b0
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [NW:0]             rem_in,
    input  logic [NW-1:0]           den_in,
    input  logic [tccc_pkg::QW-1:0] q_in,
    output logic [NW:0]             rem_out,
    output logic [NW-1:0]           den_out,
    output logic [tccc_pkg::QW-1:0] q_out
);

    import tccc_pkg::*;

    logic [NW:0] shifted;
    logic        ge;

    // The first cell takes the numerator as it stands; the rest shift in a zero.
    assign shifted = FIRST ? rem_in : {rem_in[NW-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_in};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out <= ge ? shifted - {1'b0, den_in} : shifted;
            den_out <= den_in;
            q_out   <= {q_in[QW-2:0], ge};
        end
    end

endmodule

### sv/tccc_cordic_cell.sv
// One micro-rotation cell of the vectoring CORDIC.
module tccc_cordic_cell #(
    parameter int CW = 51,
    parameter int I  = 0
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [CW-1:0]           x_in,
    input  logic signed [CW-1:0]           y_in,
    input  logic signed [tccc_pkg::ZW-1:0] z_in,
    output logic signed [CW-1:0]           x_out,
    output logic signed [CW-1:0]           y_out,
    output logic signed [tccc_pkg::ZW-1:0] z_out
);

    import tccc_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed(ZW'(ATAN_DEG_TAB[I]));

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = x_in >>> I;
    assign ys = y_in >>> I;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!y_in[CW-1]) begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + ANG;
            end else begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - ANG;
            end
        end
    end

endmodule

### sv/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Usage: each transfer on the s_ channel carries one accelerometer triple and one
// magnetometer triple; each transfer on the m_ channel returns one heading in
// 1/64 degree (0 to 23039) with accel_invalid in m_tuser.
// The datapath is a row of cells: squares and sums, one square-root cell per root
// bit, one divider cell per quotient bit, four multiply and add stages, one CORDIC
// cell per stage and a final rounding stage.
// The block takes one transfer per cycle while no result waits on a stalled receiver.
// When the receiver stalls with a result waiting, the whole row holds and s_tready
// falls until that result is taken.
// cfg_wr_en writes sensor_variant: 0 subtracts the z term of compensated y, 1 adds it.
// Synchronous reset empties the row and clears sensor_variant; no clearing pass.
// A zero accelerometer vector gives accel_invalid = 1 and heading 0.
module tilt_compensated_compass_heading #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // acc_x, acc_y, acc_z, mag_x, mag_y, mag_z from the lowest bit up.
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // heading, zero padded to 16 bits.
    output logic [15:0] m_tdata,
    // accel_invalid.
    output logic [0:0]  m_tuser,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data
);

    import tccc_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int W  = 2 * S;
    localparam int PW = S + FRAC + 2;
    localparam int CW = S + FRAC + 5;
    localparam int HB = ZW - ANG_SHIFT;
    localparam int L  = S + N + 39;

    typedef struct packed {
        logic signed [S-1:0] ax;
        logic signed [S-1:0] ay;
        logic signed [S-1:0] az;
        logic signed [S-1:0] mx;
        logic signed [S-1:0] my;
        logic signed [S-1:0] mz;
        logic                invalid;
        logic                rz;
    } side_t;

    logic         en;
    logic [L-1:0] valid_reg;
    logic         sensor_variant_reg;

    assign en       = !valid_reg[L-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= '0;
            sensor_variant_reg <= 1'b0;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[L-2:0], s_tvalid};
            end
            if (cfg_wr_en) begin
                sensor_variant_reg <= cfg_wr_data;
            end
        end
    end

    // Squares and their sums.
    logic signed [S-1:0] ax_in, ay_in, az_in;
    logic signed [W-1:0] sqx, sqy, sqz;
    side_t               st0_side_reg;
    side_t               sq0_side;
    logic [W-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [W-1:0]        syz;
    logic [W-1:0]        sall;
    logic [W-1:0]        syz_reg, sall_reg;

    assign ax_in = s_tdata[S-1:0];
    assign ay_in = s_tdata[2*S-1:S];
    assign az_in = s_tdata[3*S-1:2*S];
    assign sqx   = ax_in * ax_in;
    assign sqy   = ay_in * ay_in;
    assign sqz   = az_in * az_in;
    assign syz   = sqy_reg + sqz_reg;
    assign sall  = syz + sqx_reg;

    always_comb begin
        sq0_side         = st0_side_reg;
        sq0_side.invalid = sall == '0;
        sq0_side.rz      = syz == '0;
    end

    side_t sq_side_reg [S+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_side_reg.ax      <= ax_in;
            st0_side_reg.ay      <= ay_in;
            st0_side_reg.az      <= az_in;
            st0_side_reg.mx      <= s_tdata[4*S-1:3*S];
            st0_side_reg.my      <= s_tdata[5*S-1:4*S];
            st0_side_reg.mz      <= s_tdata[6*S-1:5*S];
            st0_side_reg.invalid <= 1'b0;
            st0_side_reg.rz      <= 1'b0;
            sqx_reg              <= sqx;
            sqy_reg              <= sqy;
            sqz_reg              <= sqz;

            sq_side_reg[0]       <= sq0_side;
            syz_reg              <= syz;
            sall_reg             <= sall;
        end
    end

    // Square roots of both sums, one root bit per cell.
    logic [W-1:0] sqn_x [S+1];
    logic [W-1:0] sqn_res [S+1];
    logic [W-1:0] sqr_x [S+1];
    logic [W-1:0] sqr_res [S+1];

    assign sqn_x[0]   = sall_reg;
    assign sqn_res[0] = '0;
    assign sqr_x[0]   = syz_reg;
    assign sqr_res[0] = '0;

    for (genvar k = 0; k < S; k++) begin : g_sqrt
        tccc_sqrt_cell #(.W(W), .J(S - 1 - k)) u_sqrt_n (
            .aclk    (aclk),
            .en      (en),
            .x_in    (sqn_x[k]),
            .res_in  (sqn_res[k]),
            .x_out   (sqn_x[k+1]),
            .res_out (sqn_res[k+1])
        );
        tccc_sqrt_cell #(.W(W), .J(S - 1 - k)) u_sqrt_r (
            .aclk    (aclk),
            .en      (en),
            .x_in    (sqr_x[k]),
            .res_in  (sqr_res[k]),
            .x_out   (sqr_x[k+1]),
            .res_out (sqr_res[k+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // Four divider lanes: sin pitch, cos pitch, sin roll and cos roll magnitudes.
    side_t        sqs;
    logic [S-1:0] root_n, root_r, den_r;
    logic [S-1:0] abs_ax, abs_ay, abs_az;

    assign sqs    = sq_side_reg[S];
    assign root_n = sqn_res[S][S-1:0];
    assign root_r = sqr_res[S][S-1:0];
    assign den_r  = sqs.rz ? S'(1) : root_r;
    assign abs_ax = sqs.ax[S-1] ? -sqs.ax : sqs.ax;
    assign abs_ay = sqs.ay[S-1] ? -sqs.ay : sqs.ay;
    assign abs_az = sqs.az[S-1] ? -sqs.az : sqs.az;

    logic [S:0]    dv_rem [4][QW+1];
    logic [S-1:0]  dv_den [4][QW+1];
    logic [QW-1:0] dv_q [4][QW+1];
    side_t         dv_side_reg [1:QW];

    assign dv_rem[0][0] = {1'b0, abs_ax};
    assign dv_den[0][0] = root_n;
    assign dv_rem[1][0] = {1'b0, root_r};
    assign dv_den[1][0] = root_n;
    assign dv_rem[2][0] = {1'b0, abs_ay};
    assign dv_den[2][0] = den_r;
    assign dv_rem[3][0] = {1'b0, abs_az};
    assign dv_den[3][0] = den_r;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign dv_q[l][0] = '0;
        for (genvar k = 0; k < QW; k++) begin : g_div
            tccc_div_cell #(.NW(S), .FIRST(k == 0)) u_div (
                .aclk    (aclk),
                .en      (en),
                .rem_in  (dv_rem[l][k]),
                .den_in  (dv_den[l][k]),
                .q_in    (dv_q[l][k]),
                .rem_out (dv_rem[l][k+1]),
                .den_out (dv_den[l][k+1]),
                .q_out   (dv_q[l][k+1])
            );
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_dv_side
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_side_reg[1] <= sqs;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_side_reg[k+1] <= dv_side_reg[k];
                end
            end
        end
    end

    // Products of the sines and cosines, then the signed terms, the magnetometer products and the compensated x and y.
    side_t                  dvs;
    logic [QW-1:0]          msr, mcr;
    side_t                  m1_side_reg;
    logic [2*QW-1:0]        m1_p1_reg, m1_p2_reg;
    logic [QW-1:0]          m1_sp_reg, m1_cp_reg, m1_cr_reg;
    logic                   m1_nsp_reg, m1_nsr_reg;
    side_t                  m2_side_reg;
    logic signed [QW:0]     m2_sp_reg, m2_cp_reg, m2_cr_reg, m2_q1_reg, m2_q2_reg;
    logic [QW-1:0]          q1_mag, q2_mag;
    logic                   m3_inv_reg;
    logic signed [PW-1:0]   m3_t1_reg, m3_t2_reg, m3_t3_reg, m3_t4_reg, m3_t5_reg;
    logic                   m4_inv_reg;
    logic signed [CW-1:0]   m4_x_reg, m4_y_reg;
    logic signed [CW-1:0]   y_base;

    assign dvs    = dv_side_reg[QW];
    assign msr    = dvs.rz ? '0 : dv_q[2][QW];
    assign mcr    = dvs.rz ? QW'(1) << FRAC : dv_q[3][QW];
    assign q1_mag = QW'(m1_p1_reg >> FRAC);
    assign q2_mag = QW'(m1_p2_reg >> FRAC);
    assign y_base = CW'(m3_t3_reg) + CW'(m3_t4_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_side_reg <= dvs;
            m1_p1_reg   <= msr * dv_q[0][QW];
            m1_p2_reg   <= msr * dv_q[1][QW];
            m1_sp_reg   <= dv_q[0][QW];
            m1_cp_reg   <= dv_q[1][QW];
            m1_cr_reg   <= mcr;
            m1_nsp_reg  <= dvs.ax[S-1];
            // Sine of roll is negative when the y sample is positive.
            m1_nsr_reg  <= !dvs.ay[S-1] && dvs.ay != '0;

            m2_side_reg <= m1_side_reg;
            m2_sp_reg   <= m1_nsp_reg ? -$signed({1'b0, m1_sp_reg}) : $signed({1'b0, m1_sp_reg});
            m2_cp_reg   <= $signed({1'b0, m1_cp_reg});
            m2_cr_reg   <= $signed({1'b0, m1_cr_reg});
            m2_q1_reg   <= (m1_nsr_reg ^ m1_nsp_reg) ? -$signed({1'b0, q1_mag})
                                                     : $signed({1'b0, q1_mag});
            m2_q2_reg   <= m1_nsr_reg ? -$signed({1'b0, q2_mag}) : $signed({1'b0, q2_mag});

            m3_inv_reg  <= m2_side_reg.invalid;
            m3_t1_reg   <= m2_side_reg.mx * m2_cp_reg;
            m3_t2_reg   <= m2_side_reg.mz * m2_sp_reg;
            m3_t3_reg   <= m2_side_reg.mx * m2_q1_reg;
            m3_t4_reg   <= m2_side_reg.my * m2_cr_reg;
            m3_t5_reg   <= m2_side_reg.mz * m2_q2_reg;

            m4_inv_reg  <= m3_inv_reg;
            m4_x_reg    <= CW'(m3_t1_reg) + CW'(m3_t2_reg);
            m4_y_reg    <= sensor_variant_reg ? y_base + CW'(m3_t5_reg)
                                              : y_base - CW'(m3_t5_reg);
        end
    end

    // Vectoring CORDIC; a vector in the left half plane is first turned by 180 degrees.
    logic signed [CW-1:0] cx [N+1];
    logic signed [CW-1:0] cy [N+1];
    logic signed [ZW-1:0] cz [N+1];
    logic signed [CW-1:0] c0_x_reg, c0_y_reg;
    logic signed [ZW-1:0] c0_z_reg;
    logic [N:0]           cf_inv_reg, cf_zero_reg;

    assign cx[0] = c0_x_reg;
    assign cy[0] = c0_y_reg;
    assign cz[0] = c0_z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cf_inv_reg  <= {cf_inv_reg[N-1:0], m4_inv_reg};
            cf_zero_reg <= {cf_zero_reg[N-1:0], m4_x_reg == '0 && m4_y_reg == '0};
            if (m4_x_reg[CW-1]) begin
                c0_x_reg <= -m4_x_reg;
                c0_y_reg <= -m4_y_reg;
                c0_z_reg <= ZW'(ANG_HALF_TURN);
            end else begin
                c0_x_reg <= m4_x_reg;
                c0_y_reg <= m4_y_reg;
                c0_z_reg <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cordic
        tccc_cordic_cell #(.CW(CW), .I(k)) u_cordic (
            .aclk  (aclk),
            .en    (en),
            .x_in  (cx[k]),
            .y_in  (cy[k]),
            .z_in  (cz[k]),
            .x_out (cx[k+1]),
            .y_out (cy[k+1]),
            .z_out (cz[k+1])
        );
    end

    // Rounding to 1/64 degree and wrapping into one turn.
    logic signed [ZW-1:0] z_round;
    logic signed [HB-1:0] h0, h1, h2;
    logic [HEADING_W-1:0] heading_reg;
    logic                 invalid_reg;

    assign z_round = cz[N] + ZW'(ANG_ROUND);
    assign h0      = z_round[ZW-1:ANG_SHIFT];
    assign h1      = h0[HB-1] ? h0 + HB'(TURN_UNITS) : h0;
    assign h2      = (h1 >= $signed(HB'(TURN_UNITS))) ? h1 - HB'(TURN_UNITS) : h1;

    always_ff @(posedge aclk) begin
        if (en) begin
            invalid_reg <= cf_inv_reg[N];
            heading_reg <= (cf_inv_reg[N] || cf_zero_reg[N]) ? '0 : h2[HEADING_W-1:0];
        end
    end

    assign m_tdata = {1'b0, heading_reg};
    assign m_tuser = invalid_reg;

endmodule
